[src/http_root_path_matcher_defines.svh]
// Assertion macros used by the matcher top level.
// No dependencies; included by files that carry concurrent checks.
`ifndef HTTP_ROOT_PATH_MATCHER_DEFINES_SVH
`define HTTP_ROOT_PATH_MATCHER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define HRPM_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hrpm: implication check failed");

// next-cycle implication, disabled during reset
`define HRPM_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hrpm: next-cycle check failed");

`endif

[src/hrpm_pkg.sv]
// Types and constants for the HTTP root-path matcher.
// No dependencies; used by all modules of the block.
package hrpm_pkg;

    localparam logic [7:0]  CH_CR      = 8'h0D;
    localparam logic [7:0]  CH_LF      = 8'h0A;
    localparam logic [7:0]  CH_SLASH   = 8'h2F;
    localparam logic [31:0] TOKEN_GET  = 32'h4745_5420;
    localparam logic [39:0] TOKEN_POST = 40'h50_4F53_5420;
    localparam logic [15:0] SUFFIX_LEN = 16'd9;

    // path search status
    localparam logic [1:0] SRCH_NONE   = 2'd0;
    localparam logic [1:0] SRCH_ACTIVE = 2'd1;
    localparam logic [1:0] SRCH_DONE   = 2'd2;

    // method codes
    localparam logic [1:0] METH_NONE = 2'd0;
    localparam logic [1:0] METH_GET  = 2'd1;
    localparam logic [1:0] METH_POST = 2'd2;

    // match status codes
    localparam logic [1:0] MATCH_NONE    = 2'd0;
    localparam logic [1:0] MATCH_PATH    = 2'd1;
    localparam logic [1:0] MATCH_PARTIAL = 2'd2;

    // header end tracker: 4 = blank line seen, latched
    localparam logic [2:0] HDR_END = 3'd4;

    typedef struct packed {
        logic [15:0] pos;
        logic [39:0] recent;
        logic [2:0]  hdr;
        logic [1:0]  prefix;
        logic [1:0]  get_status;
        logic [15:0] get_start;
        logic [15:0] get_count;
        logic [1:0]  post_status;
        logic [15:0] post_start;
        logic [15:0] post_count;
        logic [1:0]  root_flags;
    } t_state;

    typedef struct packed {
        logic        rewrite;
        logic [1:0]  method_found;
        logic [1:0]  match_status;
        logic [15:0] path_offset;
        logic [15:0] path_length;
    } t_result;

endpackage

[src/hrpm_scan.sv]
// Per-byte next-state logic: header tracker, token search, path measure.
// Depends on hrpm_pkg.
module hrpm_scan #(
    parameter int unsigned PAYLOAD_MAX = 65535
) (
    input  hrpm_pkg::t_state i_state,
    input  logic [7:0]       i_byte,
    output hrpm_pkg::t_state o_state
);
    import hrpm_pkg::*;

    localparam logic [15:0] PosMax = 16'(PAYLOAD_MAX);

    logic [39:0] recent_nx;
    logic        is_get;
    logic        is_post;

    assign recent_nx = {i_state.recent[31:0], i_byte};
    assign is_get    = (recent_nx[31:0] == TOKEN_GET);
    assign is_post   = (recent_nx == TOKEN_POST);

    always_comb begin
        o_state = i_state;
        if (i_state.pos < PosMax) begin
            // path length counting up to CR
            if (i_state.get_status == SRCH_ACTIVE) begin
                if (i_byte == CH_CR) begin
                    o_state.get_status = SRCH_DONE;
                end else begin
                    if (i_state.get_count == 16'd0 && i_byte == CH_SLASH) begin
                        o_state.root_flags[0] = 1'b1;
                    end
                    o_state.get_count = i_state.get_count + 16'd1;
                end
            end
            if (i_state.post_status == SRCH_ACTIVE) begin
                if (i_byte == CH_CR) begin
                    o_state.post_status = SRCH_DONE;
                end else begin
                    if (i_state.post_count == 16'd0 && i_byte == CH_SLASH) begin
                        o_state.root_flags[1] = 1'b1;
                    end
                    o_state.post_count = i_state.post_count + 16'd1;
                end
            end

            // CR LF CR LF tracker; odd states expect LF
            if (i_state.hdr < HDR_END) begin
                if (i_byte == CH_CR) begin
                    o_state.hdr = i_state.hdr[0] ? 3'd0 : i_state.hdr + 3'd1;
                end else if (i_byte == CH_LF) begin
                    o_state.hdr = i_state.hdr[0] ? i_state.hdr + 3'd1 : 3'd0;
                end else begin
                    o_state.hdr = 3'd0;
                end
            end

            o_state.recent = recent_nx;
            if (i_state.pos == 16'd3 && is_get) begin
                o_state.prefix = METH_GET;
            end
            if (i_state.pos == 16'd4 && is_post) begin
                o_state.prefix = METH_POST;
            end

            if (o_state.hdr < HDR_END) begin
                if (i_state.get_status == SRCH_NONE && i_state.pos >= 16'd3 && is_get) begin
                    o_state.get_status = SRCH_ACTIVE;
                    o_state.get_start  = i_state.pos + 16'd1;
                    o_state.get_count  = 16'd0;
                end
                if (i_state.post_status == SRCH_NONE && i_state.pos >= 16'd4 && is_post) begin
                    o_state.post_status = SRCH_ACTIVE;
                    o_state.post_start  = i_state.pos + 16'd1;
                    o_state.post_count  = 16'd0;
                end
            end
            o_state.pos = i_state.pos + 16'd1;
        end
    end

endmodule

[src/hrpm_result.sv]
// End-of-payload decode: picks GET or POST path and forms the result.
// Depends on hrpm_pkg.
module hrpm_result (
    input  hrpm_pkg::t_state  i_state,
    output hrpm_pkg::t_result o_result
);
    import hrpm_pkg::*;

    logic [15:0] count;
    logic        slash;

    always_comb begin
        o_result = '0;
        count    = 16'd0;
        slash    = 1'b0;
        if (i_state.prefix != METH_NONE) begin
            if (i_state.pos <= 16'd4) begin
                o_result.method_found = METH_GET;
                o_result.match_status = MATCH_PARTIAL;
            end else if (i_state.get_status != SRCH_NONE) begin
                o_result.method_found = METH_GET;
                o_result.match_status = (i_state.get_status == SRCH_DONE) ?
                                        MATCH_PATH : MATCH_PARTIAL;
                o_result.path_offset  = i_state.get_start;
                count = i_state.get_count;
                slash = i_state.root_flags[0];
            end else if (i_state.pos <= 16'd5) begin
                o_result.method_found = METH_POST;
                o_result.match_status = MATCH_PARTIAL;
            end else if (i_state.post_status != SRCH_NONE) begin
                o_result.method_found = METH_POST;
                o_result.match_status = (i_state.post_status == SRCH_DONE) ?
                                        MATCH_PATH : MATCH_PARTIAL;
                o_result.path_offset  = i_state.post_start;
                count = i_state.post_count;
                slash = i_state.root_flags[1];
            end
        end
        if (o_result.match_status == MATCH_PATH) begin
            // drop the " HTTP/x.x" suffix
            o_result.path_length = (count > SUFFIX_LEN) ? count - SUFFIX_LEN : 16'd0;
            o_result.rewrite     = (o_result.path_length == 16'd1) && slash;
        end
    end

endmodule

[src/http_root_path_matcher.sv]
// HTTP root-path matcher, top level.
// Input channel: one payload byte per request on i_data_byte, i_last_byte
//   marks the final byte; i_in_valid / o_in_ready handshake.
// Output channel: one result per payload on o_out_valid / i_out_ready:
//   o_rewrite, o_method_found, o_match_status, o_path_offset, o_path_length.
// Bytes are registered, then the per-byte state update and, for the last
// byte, the result decode run combinationally into the result register.
// Throughput: one byte per cycle while no final byte is held back. The result
// is captured in the result register when the last byte leaves the input register.
// When the receiver stalls with a result pending, non-final bytes keep
// flowing; a final byte waits in the input register and o_in_ready drops
// until the result register frees.
// Reset clears all matcher state and empties both registers; the state is
// also cleared after every final byte, so payloads are independent.
// Bytes beyond PAYLOAD_MAX are ignored, but the final-byte mark still ends
// the payload.
// Depends on hrpm_pkg, hrpm_scan, hrpm_result and the defines header.
`include "http_root_path_matcher_defines.svh"

module http_root_path_matcher #(
    parameter int unsigned PAYLOAD_MAX = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_rewrite,
    output logic [1:0]  o_method_found,
    output logic [1:0]  o_match_status,
    output logic [15:0] o_path_offset,
    output logic [15:0] o_path_length
);
    import hrpm_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    t_state     r_state;
    t_state     n_state;
    t_result    n_res;
    t_result    r_res;
    logic       r_out_valid;
    logic       out_free;
    logic       step_en;

    assign out_free   = !r_out_valid || i_out_ready;
    assign step_en    = r_in_valid && (!r_in_last || out_free);
    assign o_in_ready = !r_in_valid || step_en;

    hrpm_scan #(
        .PAYLOAD_MAX(PAYLOAD_MAX)
    ) u_scan (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .o_state (n_state)
    );

    hrpm_result u_result (
        .i_state  (n_state),
        .o_result (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (step_en) begin
            r_state <= r_in_last ? '0 : n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_en && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_en && r_in_last) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_rewrite      = r_res.rewrite;
    assign o_method_found = r_res.method_found;
    assign o_match_status = r_res.match_status;
    assign o_path_offset  = r_res.path_offset;
    assign o_path_length  = r_res.path_length;

    `HRPM_ASSERT_IMP(a_rewrite_needs_root, i_clk, i_rst_n,
        r_out_valid && r_res.rewrite,
        r_res.match_status == MATCH_PATH && r_res.path_length == 16'd1)
    `HRPM_ASSERT_IMP(a_no_method_no_match, i_clk, i_rst_n,
        r_out_valid && r_res.method_found == METH_NONE,
        r_res.match_status == MATCH_NONE && r_res.path_offset == 16'd0)
    `HRPM_ASSERT_NXT(a_clear_after_last, i_clk, i_rst_n,
        step_en && r_in_last,
        r_state.pos == 16'd0 && r_state.get_status == SRCH_NONE && r_out_valid)
    `HRPM_ASSERT_IMP(a_state_codes_legal, i_clk, i_rst_n,
        1'b1,
        r_state.hdr <= HDR_END && r_state.get_status != 2'd3 &&
        r_state.post_status != 2'd3)
    `HRPM_ASSERT_NXT(a_stalled_result_kept, i_clk, i_rst_n,
        r_out_valid && !i_out_ready,
        r_out_valid && $stable(r_res))

endmodule

[tb/sv/hrpm_result_checker.sv]
`timescale 1ns / 100ps
// Result checker for http_root_path_matcher: follows the matcher state byte by byte,
// predicts the result of each request payload and compares what the block emits.
// Depends on hrpm_pkg for the result struct, token and code constants.
module hrpm_result_checker #(
    parameter int unsigned PAYLOAD_MAX = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_rewrite,
    input  logic [1:0]  i_method_found,
    input  logic [1:0]  i_match_status,
    input  logic [15:0] i_path_offset,
    input  logic [15:0] i_path_length,
    output int          o_fail_count,
    output int          o_pending
);
    import hrpm_pkg::*;

    localparam logic [15:0] GET_TOKEN_LEN  = 16'd4;
    localparam logic [15:0] POST_TOKEN_LEN = 16'd5;
    localparam int          PRINT_LIMIT    = 100;

    logic [15:0] byte_pos;
    logic [39:0] last5;
    logic [2:0]  hdr_state;
    logic [1:0]  lead_method;
    logic [1:0]  get_status;
    logic [15:0] get_start;
    logic [15:0] get_len;
    logic [1:0]  post_status;
    logic [15:0] post_start;
    logic [15:0] post_len;
    logic [1:0]  slash_first;

    t_result     path_results_q[$];
    int          fail_count = 0;
    int          printed    = 0;
    int          pending_n  = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_n;

    task automatic report_fault(input string msg);
        fail_count++;
        if (printed < PRINT_LIMIT) begin
            $display("%0t hrpm mismatch: %s", $realtime, msg);
            printed++;
        end
    endtask

    task automatic clear_payload();
        byte_pos    = '0;
        last5       = '0;
        hdr_state   = '0;
        lead_method = METH_NONE;
        get_status  = SRCH_NONE;
        get_start   = '0;
        get_len     = '0;
        post_status = SRCH_NONE;
        post_start  = '0;
        post_len    = '0;
        slash_first = '0;
    endtask

    // advance the matcher state by one payload byte; on the last byte,
    // queue the result and start over
    task automatic track_byte(input logic [7:0] b, input logic last);
        logic [15:0] p;
        logic [15:0] count;
        logic        slash;
        t_result     r;
        if (byte_pos < PAYLOAD_MAX) begin
            p = byte_pos;
            if (get_status == SRCH_ACTIVE) begin
                if (b == CH_CR) begin
                    get_status = SRCH_DONE;
                end else begin
                    if (get_len == 16'd0 && b == CH_SLASH) slash_first[0] = 1'b1;
                    get_len = get_len + 16'd1;
                end
            end
            if (post_status == SRCH_ACTIVE) begin
                if (b == CH_CR) begin
                    post_status = SRCH_DONE;
                end else begin
                    if (post_len == 16'd0 && b == CH_SLASH) slash_first[1] = 1'b1;
                    post_len = post_len + 16'd1;
                end
            end
            // CR LF CR LF tracker, latched once the blank line is seen
            if (hdr_state < HDR_END) begin
                if (b == CH_CR) hdr_state = hdr_state[0] ? 3'd0 : hdr_state + 3'd1;
                else if (b == CH_LF) hdr_state = hdr_state[0] ? hdr_state + 3'd1 : 3'd0;
                else hdr_state = 3'd0;
            end
            last5 = {last5[31:0], b};
            if (p == GET_TOKEN_LEN - 16'd1 && last5[31:0] == TOKEN_GET)
                lead_method = METH_GET;
            if (p == POST_TOKEN_LEN - 16'd1 && last5 == TOKEN_POST)
                lead_method = METH_POST;
            if (hdr_state < HDR_END) begin
                if (get_status == SRCH_NONE && p >= GET_TOKEN_LEN - 16'd1 &&
                    last5[31:0] == TOKEN_GET) begin
                    get_status = SRCH_ACTIVE;
                    get_start  = p + 16'd1;
                    get_len    = '0;
                end
                if (post_status == SRCH_NONE && p >= POST_TOKEN_LEN - 16'd1 &&
                    last5 == TOKEN_POST) begin
                    post_status = SRCH_ACTIVE;
                    post_start  = p + 16'd1;
                    post_len    = '0;
                end
            end
            byte_pos = p + 16'd1;
        end
        if (last) begin
            r     = '0;
            count = '0;
            slash = 1'b0;
            r.method_found = METH_NONE;
            r.match_status = MATCH_NONE;
            if (lead_method != METH_NONE) begin
                if (byte_pos <= GET_TOKEN_LEN) begin
                    r.method_found = METH_GET;
                    r.match_status = MATCH_PARTIAL;
                end else if (get_status != SRCH_NONE) begin
                    r.method_found = METH_GET;
                    r.match_status = (get_status == SRCH_DONE) ? MATCH_PATH : MATCH_PARTIAL;
                    r.path_offset  = get_start;
                    count          = get_len;
                    slash          = slash_first[0];
                end else if (byte_pos <= POST_TOKEN_LEN) begin
                    r.method_found = METH_POST;
                    r.match_status = MATCH_PARTIAL;
                end else if (post_status != SRCH_NONE) begin
                    r.method_found = METH_POST;
                    r.match_status = (post_status == SRCH_DONE) ? MATCH_PATH : MATCH_PARTIAL;
                    r.path_offset  = post_start;
                    count          = post_len;
                    slash          = slash_first[1];
                end
            end
            if (r.match_status == MATCH_PATH) begin
                r.path_length = (count > SUFFIX_LEN) ? count - SUFFIX_LEN : 16'd0;
                r.rewrite     = (r.path_length == 16'd1) && slash;
            end
            path_results_q.push_back(r);
            clear_payload();
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            clear_payload();
            path_results_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) track_byte(i_data_byte, i_last_byte);
            if (i_out_valid && i_out_ready) begin
                if (path_results_q.size() == 0) begin
                    report_fault("result with no request pending");
                end else begin
                    want = path_results_q.pop_front();
                    if (i_rewrite !== want.rewrite)
                        report_fault($sformatf("rewrite %b, want %b", i_rewrite, want.rewrite));
                    if (i_method_found !== want.method_found)
                        report_fault($sformatf("method_found %0d, want %0d",
                                               i_method_found, want.method_found));
                    if (i_match_status !== want.match_status)
                        report_fault($sformatf("match_status %0d, want %0d",
                                               i_match_status, want.match_status));
                    if (i_path_offset !== want.path_offset)
                        report_fault($sformatf("path_offset %0d, want %0d",
                                               i_path_offset, want.path_offset));
                    if (i_path_length !== want.path_length)
                        report_fault($sformatf("path_length %0d, want %0d",
                                               i_path_length, want.path_length));
                end
            end
        end
        pending_n = path_results_q.size();
    end

endmodule

[tb/sv/http_root_path_matcher_test.sv]
`timescale 1ns / 100ps
// Top of the http_root_path_matcher testbench: clock, reset, request payloads
// (directed, then random) and result-side stalls; gives the verdict.
// Depends on hrpm_pkg, the matcher RTL and hrpm_result_checker.
module http_root_path_matcher_test;
    import hrpm_pkg::*;

    localparam int unsigned PAYLOAD_MAX     = 65535;
    localparam int          RESET_CYCLES    = 12;
    localparam int          HOLD_CYCLES     = 300;
    localparam int          DRAIN_CYCLES    = 8;
    localparam int          RANDOM_BYTES    = 250;
    localparam int          RANDOM_PAYLOADS = 6;
    localparam int          PRESSURE_AT     = 2;
    localparam longint      TIMEOUT_NS      = 30_000_000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        rewrite;
    logic [1:0]  method_found;
    logic [1:0]  match_status;
    logic [15:0] path_offset;
    logic [15:0] path_length;

    int          fail_count;
    int          pending_n;
    int          send_level    = 1;
    int          recv_level    = 1;
    bit          hold_req      = 1'b0;
    int          bytes_sent    = 0;
    int          payloads_sent = 0;
    logic [7:0]  payload_q[$];

    always #6 clk = ~clk;

    http_root_path_matcher #(
        .PAYLOAD_MAX(PAYLOAD_MAX)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_data_byte    (data_byte),
        .i_last_byte    (last_byte),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_rewrite      (rewrite),
        .o_method_found (method_found),
        .o_match_status (match_status),
        .o_path_offset  (path_offset),
        .o_path_length  (path_length)
    );

    hrpm_result_checker #(
        .PAYLOAD_MAX(PAYLOAD_MAX)
    ) checker_i (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_data_byte    (data_byte),
        .i_last_byte    (last_byte),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_rewrite      (rewrite),
        .i_method_found (method_found),
        .i_match_status (match_status),
        .i_path_offset  (path_offset),
        .i_path_length  (path_length),
        .o_fail_count   (fail_count),
        .o_pending      (pending_n)
    );

    // 0: never waits, 1: waits now and then, 2: waits often
    function automatic int draw_wait(input int level);
        if (level == 0) return 0;
        if (level == 1) return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 13) : 0;
        return $urandom_range(0, 13);
    endfunction

    // bytes biased toward token and line-end characters
    function automatic logic [7:0] pick_char();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 9))
                0: b = "G";
                1: b = "E";
                2: b = "T";
                3: b = " ";
                4: b = "P";
                5: b = "O";
                6: b = "S";
                7: b = CH_SLASH;
                8: b = CH_CR;
                default: b = CH_LF;
            endcase
        end
        return b;
    endfunction

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) payload_q.push_back(s[i]);
    endtask

    task automatic put_crlf();
        payload_q.push_back(CH_CR);
        payload_q.push_back(CH_LF);
    endtask

    task automatic put_line(input string s);
        put_text(s);
        put_crlf();
    endtask

    task automatic put_noise(input int n);
        repeat (n) payload_q.push_back(pick_char());
    endtask

    task automatic put_path();
        case ($urandom_range(0, 4))
            0, 1: put_text("/");
            2: begin
                put_text("/");
                repeat ($urandom_range(1, 12))
                    payload_q.push_back(8'($urandom_range(8'h61, 8'h7a)));
            end
            3: repeat ($urandom_range(0, 6))
                payload_q.push_back(8'($urandom_range(8'h21, 8'h7e)));
            default: put_noise($urandom_range(0, 4));
        endcase
    endtask

    task automatic put_token();
        if ($urandom_range(0, 1) == 0) put_text("GET ");
        else put_text("POST ");
    endtask

    // one byte per request, last byte marked; sender gaps per byte
    task automatic send_payload();
        int gap;
        for (int i = 0; i < payload_q.size(); i++) begin
            gap = draw_wait(send_level);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid  <= 1'b1;
            data_byte <= payload_q[i];
            last_byte <= (i == payload_q.size() - 1);
            do @(posedge clk); while (!in_ready);
            bytes_sent++;
        end
        payload_q.delete();
        payloads_sent++;
    endtask

    // mostly well-formed request headers with random content, some noise
    task automatic build_random_request();
        int cut;
        if ($urandom_range(0, 9) == 0) begin
            put_noise($urandom_range(1, 24));
        end else begin
            case ($urandom_range(0, 6))
                0, 1, 2: put_text("GET ");
                3, 4:    put_text("POST ");
                5:       put_text("HEAD ");
                default: put_noise($urandom_range(1, 6));
            endcase
            put_path();
            if ($urandom_range(0, 7) != 0) put_text(" HTTP/1.1");
            else put_noise($urandom_range(0, 12));
            if ($urandom_range(0, 7) != 0) put_crlf();
            repeat ($urandom_range(0, 3)) begin
                put_text("Host: h");
                put_noise($urandom_range(0, 6));
                put_crlf();
            end
            if ($urandom_range(0, 3) == 0) begin
                put_token();
                put_path();
                put_line(" HTTP/1.0");
            end
            if ($urandom_range(0, 5) != 0) put_crlf();
            // body may hold tokens that must not count
            if ($urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 1) == 0) put_token();
                put_path();
                put_noise($urandom_range(0, 16));
            end
            if ($urandom_range(0, 5) == 0) begin
                cut = $urandom_range(1, payload_q.size());
                while (payload_q.size() > cut) void'(payload_q.pop_back());
            end
        end
    endtask

    initial begin : stimulus
        int rand_bytes_base;
        int rand_payloads_base;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed requests
        put_line("GET / HTTP/1.1"); put_line("Host: a"); put_crlf(); send_payload();
        put_line("POST / HTTP/1.1"); put_crlf(); send_payload();
        put_line("GET /index.html HTTP/1.1"); put_crlf(); send_payload();
        put_text("GET "); send_payload();
        put_text("GET"); send_payload();
        put_text("POST "); send_payload();
        put_text("POS"); send_payload();
        put_text("GET / HTTP/1.1"); send_payload();
        put_line("HELLO GET / HTTP/1.1"); send_payload();
        put_line("POST /x HTTP/1.1"); put_line("GET / HTTP/1.1"); put_crlf(); send_payload();
        put_line("POST GET / HTTP/1.1"); send_payload();
        put_line("GET /a HTTP/1.1"); put_crlf(); put_line("POST / HTTP/1.1"); send_payload();
        put_line("POST /x HTTP/1.1"); put_crlf(); put_line("GET / HTTP/1.1"); send_payload();
        put_line("GET /"); send_payload();
        put_line("GET x HTTP/1.1"); send_payload();
        put_line("POST /abc HTTP/1.1"); put_text("GET /b"); send_payload();
        put_line("GET / HTTP/1.1"); put_crlf(); send_payload();
        put_text("GET / HTTP/1.1"); payload_q.push_back(CH_CR); payload_q.push_back(CH_CR);
        put_crlf(); put_crlf(); send_payload();
        payload_q.push_back(8'h00); send_payload();
        payload_q.push_back(8'hFF); send_payload();

        rand_bytes_base    = bytes_sent;
        rand_payloads_base = payloads_sent;
        while (bytes_sent - rand_bytes_base < RANDOM_BYTES ||
               payloads_sent - rand_payloads_base < RANDOM_PAYLOADS) begin
            if ((payloads_sent - rand_payloads_base) % 12 == 0) begin
                send_level = $urandom_range(0, 2);
                recv_level = $urandom_range(0, 2);
            end
            // long result-side hold while requests keep coming
            if (payloads_sent - rand_payloads_base == PRESSURE_AT) begin
                hold_req   = 1'b1;
                send_level = 0;
            end
            build_random_request();
            send_payload();
        end
        in_valid  <= 1'b0;
        last_byte <= 1'b0;

        @(posedge clk);
        while (pending_n != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_n == 0) begin
            $display("[http_root_path_matcher] OK");
        end else begin
            $display("[http_root_path_matcher] ERROR");
        end
        $finish;
    end

    initial begin : result_sink
        int gap;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                gap = draw_wait(recv_level);
                if (gap > 0) begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("[http_root_path_matcher] ERROR");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/hrpm_pkg.sv
src/hrpm_scan.sv
src/hrpm_result.sv
src/http_root_path_matcher.sv
tb/sv/hrpm_result_checker.sv
tb/sv/http_root_path_matcher_test.sv
